@@ src/mtg_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and word functions of the twister generator
package mtg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int ADDR_W       = $clog2(STATE_WORDS + 1);
    localparam int WORD_W       = 32;

    localparam logic [ADDR_W-1:0] LAST_IDX   = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] END_IDX    = ADDR_W'(STATE_WORDS);
    localparam logic [ADDR_W-1:0] FAR_OFFSET = ADDR_W'(SHIFT_OFFSET);
    localparam logic [ADDR_W-1:0] FAR_WRAP   = ADDR_W'(STATE_WORDS - SHIFT_OFFSET);

    localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [WORD_W-1:0] word_t;

    // index of the word after k, wrapping at the end of the vector
    function automatic addr_t next_addr(input addr_t k);
        addr_t r;
        if (k == LAST_IDX)
        begin
            r = '0;
        end
        else
        begin
            r = k + ADDR_W'(1);
        end
        return r;
    endfunction

    // index k + offset, wrapping at the end of the vector
    function automatic addr_t far_addr(input addr_t k);
        addr_t r;
        if (k < FAR_WRAP)
        begin
            r = k + FAR_OFFSET;
        end
        else
        begin
            r = k - FAR_WRAP;
        end
        return r;
    endfunction

    // knuth initializer step
    function automatic word_t seed_next(input word_t prev, input addr_t idx);
        word_t x;
        word_t p;
        x = prev ^ (prev >> 30);
        p = INIT_MULT * x;
        return p + WORD_W'(idx);
    endfunction

    function automatic word_t twist_word(input word_t far_w, input word_t cur_w,
                                        input word_t nxt_w, input logic legacy);
        word_t mixed;
        logic  lowbit;
        mixed  = {cur_w[WORD_W-1], nxt_w[WORD_W-2:0]};
        lowbit = legacy ? cur_w[0] : nxt_w[0];
        return far_w ^ (mixed >> 1) ^ (lowbit ? TWIST_MATRIX : '0);
    endfunction

    function automatic word_t temper(input word_t w);
        word_t y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

@@ src/mersenne_twister_generator_top.sv @@
`timescale 1ns / 1ps
// top level of the mt19937 generator: sequencer around the state memory
//
// command channel (cmd_valid / cmd_stall): opcode, seed_value, legacy_mode.
// response channel (rsp_valid / rsp_stall): random_word, one per draw only.
// a transfer happens on a rising edge with valid high and stall low.
// a seed writes 624 words with the initializer, one per cycle, then twists
// the whole vector one word per cycle; the block is busy after the transfer
// until the twist ends and gives no response.
// a draw reads one word from the state memory and tempers it: a command
// passes through ST_DR_RD and ST_DR_OUT, where its response is registered,
// before the next is taken; when all 624 words are used the draw first
// twists the vector. the memory read port sets the draw time.
// a draw before any seed returns zero and changes nothing.
// cmd_stall is high while a command is in progress; a draw result waits in
// the output register while rsp_stall is high, and the next command is
// taken meanwhile, holding only a following draw.
// reset clears the control state: unseeded, read index past the end.
module mersenne_twister_generator_top
    import mtg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic        opcode,
    input  logic [31:0] seed_value,
    input  logic        legacy_mode,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] random_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_TW_PRE,
        ST_TW_LOAD,
        ST_TW_CALC,
        ST_DR_RD,
        ST_DR_OUT
    } state_t;

    state_t state_reg;
    addr_t  idx_reg;
    addr_t  read_index_reg;
    word_t  prev_reg;
    word_t  cur_reg;
    logic   legacy_reg;
    logic   seeded_reg;
    logic   draw_pending_reg;
    logic   zero_reg;
    logic   rsp_valid_reg;
    word_t  rsp_word_reg;

    logic   wr_en;
    addr_t  wr_addr;
    word_t  wr_data;
    addr_t  rd_addr_a;
    addr_t  rd_addr_b;
    word_t  rd_data_a;
    word_t  rd_data_b;
    word_t  seed_word;
    word_t  twist_out;
    addr_t  step_next;
    logic   cmd_take;
    logic   rsp_free;

    assign cmd_stall   = (state_reg != ST_IDLE);
    assign cmd_take    = cmd_valid && !cmd_stall;
    assign rsp_valid   = rsp_valid_reg;
    assign random_word = rsp_word_reg;
    assign rsp_free    = !rsp_valid_reg || !rsp_stall;

    assign seed_word = seed_next(prev_reg, idx_reg);
    assign twist_out = twist_word(rd_data_b, cur_reg, rd_data_a, legacy_reg);
    assign step_next = idx_reg + ADDR_W'(1);

    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = idx_reg;
        wr_data   = seed_word;
        rd_addr_a = read_index_reg;
        rd_addr_b = far_addr(step_next);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take && opcode == OP_SEED)
                begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = seed_value;
                end
            end
            ST_SEED:
            begin
                wr_en = 1'b1;
            end
            ST_TW_PRE:
            begin
                rd_addr_a = '0;
            end
            ST_TW_LOAD:
            begin
                rd_addr_a = next_addr('0);
                rd_addr_b = far_addr('0);
            end
            ST_TW_CALC:
            begin
                wr_en     = 1'b1;
                wr_data   = twist_out;
                rd_addr_a = next_addr(step_next);
            end
            ST_DR_RD, ST_DR_OUT:
            begin
                rd_addr_a = read_index_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    mtg_state_ram #(
        .DEPTH  (STATE_WORDS),
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            read_index_reg   <= END_IDX;
            legacy_reg       <= 1'b0;
            seeded_reg       <= 1'b0;
            draw_pending_reg <= 1'b0;
            zero_reg         <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            prev_reg         <= '0;
            cur_reg          <= '0;
            rsp_word_reg     <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_take)
                    begin
                        if (opcode == OP_SEED)
                        begin
                            prev_reg         <= seed_value;
                            legacy_reg       <= legacy_mode;
                            seeded_reg       <= 1'b1;
                            draw_pending_reg <= 1'b0;
                            idx_reg          <= ADDR_W'(1);
                            state_reg        <= ST_SEED;
                        end
                        else if (!seeded_reg)
                        begin
                            zero_reg  <= 1'b1;
                            state_reg <= ST_DR_OUT;
                        end
                        else if (read_index_reg == END_IDX)
                        begin
                            zero_reg         <= 1'b0;
                            draw_pending_reg <= 1'b1;
                            state_reg        <= ST_TW_PRE;
                        end
                        else
                        begin
                            zero_reg  <= 1'b0;
                            state_reg <= ST_DR_RD;
                        end
                    end
                end
                ST_SEED:
                begin
                    prev_reg <= seed_word;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_TW_PRE;
                    end
                    else
                    begin
                        idx_reg <= step_next;
                    end
                end
                ST_TW_PRE:
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_TW_LOAD;
                end
                ST_TW_LOAD:
                begin
                    cur_reg   <= rd_data_a;
                    state_reg <= ST_TW_CALC;
                end
                ST_TW_CALC:
                begin
                    // the word read as next becomes the current word of the next step
                    cur_reg <= rd_data_a;
                    if (idx_reg == LAST_IDX)
                    begin
                        read_index_reg <= '0;
                        state_reg      <= draw_pending_reg ? ST_DR_RD : ST_IDLE;
                    end
                    else
                    begin
                        idx_reg <= step_next;
                    end
                end
                ST_DR_RD:
                begin
                    draw_pending_reg <= 1'b0;
                    state_reg        <= ST_DR_OUT;
                end
                ST_DR_OUT:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_word_reg  <= zero_reg ? '0 : temper(rd_data_a);
                        if (!zero_reg)
                        begin
                            read_index_reg <= read_index_reg + ADDR_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/mtg_state_ram.sv @@
`timescale 1ns / 1ps
// state word memory: one write port, two registered read ports
module mtg_state_ram #(
    parameter int DEPTH  = 624,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [WIDTH-1:0]  rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
